// ===== sv/tqbp_pkg.sv =====
// Shared types, widths and the level function for the threshold quantizer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tqbp_pkg;

    localparam int VALUE_W     = 16;
    localparam int POL_W       = 4;
    localparam int LEVEL_W     = 2;
    localparam int GROUP_SIZE  = 32;
    localparam int PLANE_W     = 32;
    localparam int FILL_W      = $clog2(GROUP_SIZE);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_FIELDS_W = 4 * VALUE_W + POL_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LEVEL_W + 2 * PLANE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic MODE_UNPACKED = 1'b0;
    localparam logic MODE_PACKED   = 1'b1;
    localparam logic MODE_RESET    = MODE_PACKED;

    localparam logic signed [POL_W-1:0] POL_ZERO  = POL_W'(0);
    localparam logic signed [POL_W-1:0] POL_UP    = POL_W'(1);
    localparam logic signed [POL_W-1:0] POL_CONST = POL_W'(2);
    localparam logic signed [POL_W-1:0] POL_SAT   = POL_W'(5);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [POL_W-1:0]   pol_t;
    typedef logic [LEVEL_W-1:0]        level_t;
    typedef logic [PLANE_W-1:0]        plane_t;
    typedef logic [GROUP_SIZE-1:0]     accum_t;

    // One classified element as it travels from front to back.
    typedef struct packed {
        level_t level;
        logic   last;
    } q_item_t;

    // Map a sum and its channel thresholds to a 2-bit level.
    function automatic level_t quantize(
        input value_t sum_value,
        input value_t thr_low,
        input value_t thr_mid,
        input value_t thr_high,
        input pol_t   polarity
    );
        level_t cnt_ge;
        level_t cnt_gt;
        level_t lvl;
        cnt_ge = level_t'({1'b0, sum_value >= thr_low})
               + level_t'({1'b0, sum_value >= thr_mid})
               + level_t'({1'b0, sum_value >= thr_high});
        cnt_gt = level_t'({1'b0, sum_value > thr_low})
               + level_t'({1'b0, sum_value > thr_mid})
               + level_t'({1'b0, sum_value > thr_high});
        if (polarity >= POL_SAT) begin
            lvl = level_t'(3);
        end
        else if (polarity >= POL_CONST) begin
            lvl = polarity[LEVEL_W-1:0] - POL_CONST[LEVEL_W-1:0];
        end
        else if (polarity == POL_UP) begin
            lvl = cnt_ge;
        end
        else if (polarity < POL_ZERO) begin
            lvl = level_t'(3) - cnt_gt;
        end
        else begin
            lvl = level_t'(0);
        end
        return lvl;
    endfunction

    // Fit a group accumulator onto the output plane width.
    function automatic plane_t to_plane(input accum_t acc);
        plane_t p;
        for (int i = 0; i < PLANE_W; i++) begin
            p[i] = (i < GROUP_SIZE) ? acc[i % GROUP_SIZE] : 1'b0;
        end
        return p;
    endfunction

endpackage

// ===== sv/threshold_quantize_and_bitplane_pack_unit.sv =====
// Top level of the 2-bit threshold quantizer with bit-plane packing.
// Depends on tqbp_pkg, tqbp_front, tqbp_queue and tqbp_back.
//
// Each input transfer carries a signed sum, three thresholds and a polarity code and
// is mapped to a 2-bit level. With output_mode = 0 every input gives one output transfer
// holding the level (planes zero). With output_mode = 1 (the reset value) 32 consecutive
// levels are gathered into a low-bit and a high-bit plane word, element k in bit k; a
// group is sent when full or when tlast arrives, zero filled, with level zero. A partial
// group survives a switch to unpacked mode and resumes later. The unit accepts one item
// per clock, sustained, as long as the output side takes its results; an input transfer reaches
// the output through the front register, the two-entry queue and the output register.
// A stalled output keeps accepting items that complete no group; the queue gives the two
// sides room to stall on their own. Write cfg_we/cfg_wdata only while the unit is idle.
module threshold_quantize_and_bitplane_pack_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,     // output_mode
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // sum_value[15:0], thr_low[31:16], thr_mid[47:32], thr_high[63:48],
    // polarity[67:64], zero pad[71:68]
    input  logic [tqbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tlast,  // last_elem
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // level[1:0], low_plane[33:2], high_plane[65:34], zero pad[71:66]
    output logic [tqbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast   // last_out
);

    logic              mode_reg;
    logic              f_valid;
    tqbp_pkg::q_item_t f_item;
    logic              q_not_full;
    logic              q_not_empty;
    logic              q_pop;
    tqbp_pkg::q_item_t q_head;

    // Hold the output mode; it resets to packed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= tqbp_pkg::MODE_RESET;
        end
        else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // Classify: compare against the thresholds and register the level.
    tqbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .f_valid       (f_valid),
        .f_item        (f_item),
        .f_ready       (q_not_full)
    );

    // Decouple: advance the front item whenever the queue has room.
    tqbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && q_not_full),
        .push_item (f_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head)
    );

    // Pack or pass through, and drive the master side.
    tqbp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .output_mode   (mode_reg),
        .q_valid       (q_not_empty),
        .q_item        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/tqbp_front.sv =====
// Front stage: accept input transfers, compute the 2-bit level, hold it for the queue.
// Depends on tqbp_pkg.
module tqbp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tqbp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            f_valid,
    output tqbp_pkg::q_item_t               f_item,
    input  logic                            f_ready
);

    logic                       front_valid_reg;
    logic                       front_valid_next;
    tqbp_pkg::q_item_t          item_reg;
    tqbp_pkg::level_t           level_in;
    logic                       accept;

    assign level_in = tqbp_pkg::quantize(
        tqbp_pkg::value_t'(s_axis_tdata[tqbp_pkg::VALUE_W-1:0]),
        tqbp_pkg::value_t'(s_axis_tdata[2*tqbp_pkg::VALUE_W-1:tqbp_pkg::VALUE_W]),
        tqbp_pkg::value_t'(s_axis_tdata[3*tqbp_pkg::VALUE_W-1:2*tqbp_pkg::VALUE_W]),
        tqbp_pkg::value_t'(s_axis_tdata[4*tqbp_pkg::VALUE_W-1:3*tqbp_pkg::VALUE_W]),
        tqbp_pkg::pol_t'(s_axis_tdata[tqbp_pkg::IN_FIELDS_W-1:4*tqbp_pkg::VALUE_W]));

    // Take a new item whenever the holding register is empty or drains this cycle.
    assign s_axis_tready = !front_valid_reg || f_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign f_valid       = front_valid_reg;
    assign f_item        = item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept) begin
            front_valid_next = 1'b1;
        end
        else if (f_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            front_valid_reg <= 1'b0;
        end
        else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg.level <= level_in;
            item_reg.last  <= s_axis_tlast;
        end
    end

endmodule

// ===== sv/tqbp_queue.sv =====
// Short queue of classified items between front and back stages.
// Depends on tqbp_pkg.
module tqbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tqbp_pkg::q_item_t push_item,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output tqbp_pkg::q_item_t head_item
);

    tqbp_pkg::q_item_t                slot_mem [tqbp_pkg::QUEUE_DEPTH];
    logic [tqbp_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [tqbp_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [tqbp_pkg::QCNT_W-1:0]      count_reg;
    logic [tqbp_pkg::QCNT_W-1:0]      count_next;

    assign not_full  = count_reg != tqbp_pkg::QCNT_W'(tqbp_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = slot_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == tqbp_pkg::QPTR_W'(tqbp_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == tqbp_pkg::QPTR_W'(tqbp_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (not_full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on write");

endmodule

// ===== sv/tqbp_back.sv =====
// Back stage: pack levels into bit planes or pass them through, drive the output register.
// Depends on tqbp_pkg.
module tqbp_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             output_mode,
    input  logic                             q_valid,
    input  tqbp_pkg::q_item_t                q_item,
    output logic                             q_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tqbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);

    tqbp_pkg::accum_t               low_acc_reg;
    tqbp_pkg::accum_t               high_acc_reg;
    tqbp_pkg::accum_t               low_acc_next;
    tqbp_pkg::accum_t               high_acc_next;
    logic [tqbp_pkg::FILL_W-1:0]    fill_reg;
    logic                           out_valid_reg;
    tqbp_pkg::level_t               level_reg;
    tqbp_pkg::plane_t               low_plane_reg;
    tqbp_pkg::plane_t               high_plane_reg;
    logic                           last_reg;
    logic                           packed_mode;
    logic                           emit;
    logic                           out_free;

    assign packed_mode = output_mode == tqbp_pkg::MODE_PACKED;
    assign emit        = !packed_mode || q_item.last
                      || fill_reg == tqbp_pkg::FILL_W'(tqbp_pkg::GROUP_SIZE - 1);
    assign out_free    = !out_valid_reg || m_axis_tready;
    // Absorb items that complete no group even while the output is stalled.
    assign q_pop       = q_valid && (!emit || out_free);

    assign low_acc_next  = low_acc_reg
                         | (tqbp_pkg::accum_t'(q_item.level[0]) << fill_reg);
    assign high_acc_next = high_acc_reg
                         | (tqbp_pkg::accum_t'(q_item.level[1]) << fill_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = tqbp_pkg::OUT_TDATA_W'({high_plane_reg, low_plane_reg, level_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            low_acc_reg   <= '0;
            high_acc_reg  <= '0;
        end
        else begin
            if (out_free) begin
                out_valid_reg <= q_pop && emit;
            end
            if (q_pop && packed_mode) begin
                if (emit) begin
                    fill_reg     <= '0;
                    low_acc_reg  <= '0;
                    high_acc_reg <= '0;
                end
                else begin
                    fill_reg     <= fill_reg + 1'b1;
                    low_acc_reg  <= low_acc_next;
                    high_acc_reg <= high_acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit) begin
            last_reg <= q_item.last;
            if (packed_mode) begin
                level_reg      <= '0;
                low_plane_reg  <= tqbp_pkg::to_plane(low_acc_next);
                high_plane_reg <= tqbp_pkg::to_plane(high_acc_next);
            end
            else begin
                level_reg      <= q_item.level;
                low_plane_reg  <= '0;
                high_plane_reg <= '0;
            end
        end
    end

    a_level_xor_planes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && level_reg != '0) |-> (low_plane_reg == '0 && high_plane_reg == '0))
        else $error("result carries both a level and plane bits");

    a_unpacked_keeps_group: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !packed_mode) |=> (fill_reg == $past(fill_reg)
                                     && low_acc_reg == $past(low_acc_reg)))
        else $error("unpacked item disturbed the packing group");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && emit) |-> out_free)
        else $error("result written over an untaken result");

endmodule
